@@ rtl/mccs_pkg.sv @@
`timescale 1ns / 1ps

package mccs_pkg;

   localparam int SLOTS_DEFAULT       = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int COORD_W  = 14;
   localparam int SIZE_W   = 13;
   localparam int DIM_W    = 9;
   localparam int CHUNK_W  = 8;
   localparam int OFFSET_W = 24;
   localparam int TAG_W    = 16;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   localparam logic [SIZE_W-1:0] MAP_WIDTH_RESET     = 13'd256;
   localparam logic [SIZE_W-1:0] MAP_HEIGHT_RESET    = 13'd256;
   localparam logic [DIM_W-1:0]  CHUNK_DIM_RESET     = 9'd32;
   localparam logic [DIM_W-1:0]  CHUNKS_ACROSS_RESET = 9'd8;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH     = 2'd0,
      CSR_MAP_HEIGHT    = 2'd1,
      CSR_CHUNK_DIM     = 2'd2,
      CSR_CHUNKS_ACROSS = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_LOOKUP      = 2'd0,
      FUNC_BUMP        = 2'd1,
      FUNC_BEGIN_FRAME = 2'd2,
      FUNC_CLEAR       = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_HIT     = 2'd0,
      ST_CLAIM   = 2'd1,
      ST_NO_SLOT = 2'd2,
      ST_DONE    = 2'd3
   } status_type;

   // One classified request as it waits between the front and the back.
   typedef struct packed {
      func_type              func;
      logic [CHUNK_W-1:0]    chunk_col;
      logic [CHUNK_W-1:0]    chunk_row;
      logic [OFFSET_W-1:0]   chunk_offset;
   } entry_type;

   typedef struct packed {
      status_type            status;
      logic [1:0]            slot;
      logic [CHUNK_W-1:0]    chunk_col;
      logic [CHUNK_W-1:0]    chunk_row;
      logic [OFFSET_W-1:0]   chunk_offset;
   } result_type;

endpackage

@@ rtl/mccs_front.sv @@
`timescale 1ns / 1ps

module mccs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mccs_pkg::func_type                  req_func,
   input  logic signed [mccs_pkg::COORD_W-1:0] req_col,
   input  logic signed [mccs_pkg::COORD_W-1:0] req_row,
   input  logic                                csr_we,
   input  mccs_pkg::csr_index_type             csr_index,
   input  logic [mccs_pkg::SIZE_W-1:0]         csr_wdata,
   output logic                                push_valid,
   input  logic                                push_ready,
   output mccs_pkg::entry_type                 push_entry
);

   localparam int SW       = mccs_pkg::SIZE_W;
   localparam int DW       = mccs_pkg::DIM_W;
   localparam int CW       = mccs_pkg::CHUNK_W;
   localparam int IDX_W    = 2 * CW + 2;
   localparam int SQ_W     = 2 * DW;
   localparam int DIV_STEPS = SW;
   localparam int CNT_W    = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {S_IDLE, S_WRAP, S_DIV, S_MUL1, S_MUL2, S_PUSH} state_type;

   state_type                          state_ff;
   mccs_pkg::func_type                 func_ff;
   logic signed [mccs_pkg::COORD_W-1:0] col_raw_ff, row_raw_ff;
   logic [SW-1:0]                      map_w_ff, map_h_ff;
   logic [DW-1:0]                      dim_cfg_ff, across_ff;
   logic [DW-1:0]                      dim_ff;
   logic [SW-1:0]                      quo_x_ff, quo_y_ff;
   logic [DW-1:0]                      rem_x_ff, rem_y_ff;
   logic [CNT_W-1:0]                   cnt_ff;
   logic [CW-1:0]                      ccol_ff, crow_ff;
   logic [SQ_W-1:0]                    dimsq_ff;
   logic [IDX_W-1:0]                   idx_ff;
   logic [mccs_pkg::OFFSET_W-1:0]      off_ff;

   logic [SW-1:0]  eff_w, eff_h, wrap_x, wrap_y;
   logic [DW:0]    trial_x, trial_y;
   logic           ge_x, ge_y;
   logic [DW-1:0]  rem_x_in, rem_y_in;
   logic [SW-1:0]  quo_x_in, quo_y_in;
   logic [CW-1:0]  ccol_sat, crow_sat;
   logic [IDX_W-2:0] row_mul;
   logic [mccs_pkg::OFFSET_W-1:0] off_full;

   // Wraps a coordinate once into [0, size) and clamps what is still outside.
   function automatic logic [SW-1:0] wrap_once(input logic signed [mccs_pkg::COORD_W-1:0] x,
                                                input logic [SW-1:0] size);
      logic signed [mccs_pkg::COORD_W:0] xs;
      logic signed [mccs_pkg::COORD_W:0] ws;
      logic signed [mccs_pkg::COORD_W:0] t;
      xs = {x[mccs_pkg::COORD_W-1], x};
      ws = $signed({2'b00, size});
      if (xs < 0) begin
         t = xs + ws;
      end else if (xs >= ws) begin
         t = xs - ws;
      end else begin
         t = xs;
      end
      if (t < 0) begin
         t = '0;
      end else if (t >= ws) begin
         t = ws - (mccs_pkg::COORD_W + 1)'(1);
      end
      return t[SW-1:0];
   endfunction

   always_comb begin
      eff_w = (map_w_ff == '0) ? SW'(1) : map_w_ff;
      eff_h = (map_h_ff == '0) ? SW'(1) : map_h_ff;
      wrap_x = wrap_once(col_raw_ff, eff_w);
      wrap_y = wrap_once(row_raw_ff, eff_h);

      // One restoring step for each coordinate; the dividend shifts out on the left
      // while quotient bits shift in on the right.
      trial_x  = {rem_x_ff, quo_x_ff[SW-1]};
      trial_y  = {rem_y_ff, quo_y_ff[SW-1]};
      ge_x     = trial_x >= {1'b0, dim_ff};
      ge_y     = trial_y >= {1'b0, dim_ff};
      rem_x_in = ge_x ? DW'(trial_x - {1'b0, dim_ff}) : trial_x[DW-1:0];
      rem_y_in = ge_y ? DW'(trial_y - {1'b0, dim_ff}) : trial_y[DW-1:0];
      quo_x_in = {quo_x_ff[SW-2:0], ge_x};
      quo_y_in = {quo_y_ff[SW-2:0], ge_y};

      ccol_sat = (|quo_x_ff[SW-1:CW]) ? {CW{1'b1}} : quo_x_ff[CW-1:0];
      crow_sat = (|quo_y_ff[SW-1:CW]) ? {CW{1'b1}} : quo_y_ff[CW-1:0];
      row_mul  = (IDX_W-1)'(crow_sat) * (IDX_W-1)'(across_ff);
      off_full = mccs_pkg::OFFSET_W'(dimsq_ff) * mccs_pkg::OFFSET_W'(idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         map_w_ff   <= mccs_pkg::MAP_WIDTH_RESET;
         map_h_ff   <= mccs_pkg::MAP_HEIGHT_RESET;
         dim_cfg_ff <= mccs_pkg::CHUNK_DIM_RESET;
         across_ff  <= mccs_pkg::CHUNKS_ACROSS_RESET;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mccs_pkg::CSR_MAP_WIDTH:     map_w_ff   <= csr_wdata;
               mccs_pkg::CSR_MAP_HEIGHT:    map_h_ff   <= csr_wdata;
               mccs_pkg::CSR_CHUNK_DIM:     dim_cfg_ff <= csr_wdata[DW-1:0];
               mccs_pkg::CSR_CHUNKS_ACROSS: across_ff  <= csr_wdata[DW-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff    <= req_func;
                  col_raw_ff <= req_col;
                  row_raw_ff <= req_row;
                  dim_ff     <= (dim_cfg_ff == '0) ? DW'(1) : dim_cfg_ff;
                  if (req_func == mccs_pkg::FUNC_BEGIN_FRAME ||
                      req_func == mccs_pkg::FUNC_CLEAR) begin
                     ccol_ff  <= '0;
                     crow_ff  <= '0;
                     off_ff   <= '0;
                     state_ff <= S_PUSH;
                  end else begin
                     state_ff <= S_WRAP;
                  end
               end
            end
            S_WRAP: begin
               quo_x_ff <= wrap_x;
               quo_y_ff <= wrap_y;
               rem_x_ff <= '0;
               rem_y_ff <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               quo_x_ff <= quo_x_in;
               quo_y_ff <= quo_y_in;
               rem_x_ff <= rem_x_in;
               rem_y_ff <= rem_y_in;
               cnt_ff   <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= S_MUL1;
               end
            end
            S_MUL1: begin
               ccol_ff  <= ccol_sat;
               crow_ff  <= crow_sat;
               dimsq_ff <= SQ_W'(dim_ff) * SQ_W'(dim_ff);
               idx_ff   <= IDX_W'(row_mul) + IDX_W'(ccol_sat);
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               off_ff   <= off_full;
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               if (push_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready               = (state_ff == S_IDLE);
   assign push_valid              = (state_ff == S_PUSH);
   assign push_entry.func         = func_ff;
   assign push_entry.chunk_col    = ccol_ff;
   assign push_entry.chunk_row    = crow_ff;
   assign push_entry.chunk_offset = off_ff;

   // Restoring division keeps each partial remainder below the divisor.
   a_rem_below_dim: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (rem_x_ff < dim_ff) && (rem_y_ff < dim_ff))
      else $error("divider remainder reached the divisor");

   // The step counter runs its full length before the multiply starts.
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL1 |-> $past(cnt_ff) == CNT_W'(DIV_STEPS - 1))
      else $error("divider left early");

endmodule

@@ rtl/mccs_queue.sv @@
`timescale 1ns / 1ps

module mccs_queue #(
   parameter int DEPTH = mccs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mccs_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mccs_pkg::entry_type pop_entry
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mccs_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]       count_ff;
   logic                push_fire, pop_fire;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count above depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop_fire && !push_fire |=> count_ff == $past(count_ff) - CW'(1))
      else $error("queue count did not drop on a pop");

endmodule

@@ rtl/mccs_back.sv @@
`timescale 1ns / 1ps

module mccs_back #(
   parameter int SLOTS = mccs_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  mccs_pkg::entry_type  pop_entry,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mccs_pkg::result_type rsp_result
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [mccs_pkg::TAG_W-1:0] tag_ff [SLOTS];
   logic [SLOTS-1:0]           valid_ff, pinned_ff;
   logic                       rsp_valid_ff;
   mccs_pkg::status_type       status_ff;
   logic [SW-1:0]              slot_ff;
   logic [mccs_pkg::CHUNK_W-1:0]  ccol_ff, crow_ff;
   logic [mccs_pkg::OFFSET_W-1:0] off_ff;

   logic [mccs_pkg::TAG_W-1:0] tag;
   logic                       hit_found, empty_found, free_found;
   logic [SW-1:0]              hit_idx, empty_idx, free_idx;
   logic                       found, claim;
   logic [SW-1:0]              sel_idx;
   mccs_pkg::status_type       status;
   logic                       pop_fire;
   logic [SW+1:0]              slot_ext;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop_fire  = pop_valid && pop_ready;
   assign tag       = {pop_entry.chunk_col, pop_entry.chunk_row};

   // Priority search: the lowest matching slot wins, so scan from the top down.
   always_comb begin
      hit_found   = 1'b0;
      empty_found = 1'b0;
      free_found  = 1'b0;
      hit_idx     = '0;
      empty_idx   = '0;
      free_idx    = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_ff[i] == tag) begin
            hit_found = 1'b1;
            hit_idx   = SW'(i);
         end
         if (!valid_ff[i]) begin
            empty_found = 1'b1;
            empty_idx   = SW'(i);
         end
         if (!pinned_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   always_comb begin
      found   = 1'b0;
      claim   = 1'b0;
      sel_idx = '0;
      status  = mccs_pkg::ST_NO_SLOT;
      unique case (pop_entry.func)
         mccs_pkg::FUNC_LOOKUP: begin
            if (hit_found) begin
               found   = 1'b1;
               sel_idx = hit_idx;
               status  = mccs_pkg::ST_HIT;
            end else if (empty_found) begin
               found   = 1'b1;
               claim   = 1'b1;
               sel_idx = empty_idx;
               status  = mccs_pkg::ST_CLAIM;
            end
         end
         mccs_pkg::FUNC_BUMP: begin
            if (free_found) begin
               found   = 1'b1;
               claim   = 1'b1;
               sel_idx = free_idx;
               status  = mccs_pkg::ST_CLAIM;
            end
         end
         default: status = mccs_pkg::ST_DONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pop_fire && claim) begin
         tag_ff[sel_idx] <= tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pinned_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_fire) begin
            rsp_valid_ff <= 1'b1;
            if (pop_entry.func == mccs_pkg::FUNC_BEGIN_FRAME) begin
               pinned_ff <= '0;
            end else if (pop_entry.func == mccs_pkg::FUNC_CLEAR) begin
               valid_ff <= '0;
            end else if (found) begin
               pinned_ff[sel_idx] <= 1'b1;
               if (claim) begin
                  valid_ff[sel_idx] <= 1'b1;
               end
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         status_ff <= status;
         slot_ff   <= sel_idx;
         ccol_ff   <= pop_entry.chunk_col;
         crow_ff   <= pop_entry.chunk_row;
         off_ff    <= pop_entry.chunk_offset;
      end
   end

   assign slot_ext                = {2'b00, slot_ff};
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result.status       = status_ff;
   assign rsp_result.slot         = slot_ext[1:0];
   assign rsp_result.chunk_col    = ccol_ff;
   assign rsp_result.chunk_row    = crow_ff;
   assign rsp_result.chunk_offset = off_ff;

   // A slot reported as hit or claimed is live and pinned until the result leaves.
   a_slot_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == mccs_pkg::ST_HIT || status_ff == mccs_pkg::ST_CLAIM)
      |-> valid_ff[slot_ff] && pinned_ff[slot_ff])
      else $error("reported slot is not valid and pinned");

   // A lookup never reports a miss while an empty slot was available.
   a_no_false_miss: assert property (@(posedge clock) disable iff (reset)
      pop_fire && pop_entry.func == mccs_pkg::FUNC_LOOKUP && empty_found
      |=> status_ff != mccs_pkg::ST_NO_SLOT)
      else $error("lookup failed with an empty slot");

endmodule

@@ rtl/map_chunk_slot_cache_top.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: func; tdata: tile_col, tile_row
// rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: slot, col, row, offset
// csr      in         csr_we                 csr_index, csr_wdata (write only)
//
// A lookup or bump passes through the front as accept, wrap, 13 steps of the
// restoring divider, two multiply stages and the queue transfer; control items skip to it.
// The back resolves one queued item per cycle into the output register unless rsp stalls.
// Reset is synchronous and active high; cache state is valid-bit tracked, no clearing pass.
// A two-entry queue and the output register let a stalled rsp side back up without loss.

module map_chunk_slot_cache_top #(
   parameter int SLOTS       = mccs_pkg::SLOTS_DEFAULT,
   parameter int QUEUE_DEPTH = mccs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [13:0] tile_col, [27:14] tile_row, [31:28] zero
   input  logic [mccs_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] func
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] slot, [9:2] chunk_col, [17:10] chunk_row, [41:18] chunk_offset, [47:42] zero
   output logic [mccs_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [mccs_pkg::SIZE_W-1:0]        csr_wdata
);

   localparam int RSP_USED = 2 + 2 * mccs_pkg::CHUNK_W + mccs_pkg::OFFSET_W;

   logic                 push_valid, push_ready;
   mccs_pkg::entry_type  push_entry;
   logic                 pop_valid, pop_ready;
   mccs_pkg::entry_type  pop_entry;
   mccs_pkg::result_type result;

   mccs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (mccs_pkg::func_type'(req_tuser)),
      .req_col    ($signed(req_tdata[mccs_pkg::COORD_W-1:0])),
      .req_row    ($signed(req_tdata[2*mccs_pkg::COORD_W-1:mccs_pkg::COORD_W])),
      .csr_we     (csr_we),
      .csr_index  (mccs_pkg::csr_index_type'(csr_index)),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   mccs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   mccs_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tdata = {{(mccs_pkg::RSP_TDATA_W - RSP_USED){1'b0}},
                       result.chunk_offset, result.chunk_row, result.chunk_col, result.slot};

endmodule
